// File: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ffa_pkg.sv
// Types and constants of the first-fit block allocator.
package ffa_pkg;

  localparam int FIELD_W = 23;
  localparam int WANT_W  = FIELD_W + 1;
  localparam int ALIGN_W = 13;

  localparam int DEF_HEAP_BYTES   = 4194304;
  localparam int DEF_HEADER_BYTES = 12;
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int SPLIT_SLACK      = 32;

  localparam logic [31:0] HEAP_BASE_RESET = 32'h0040_0000;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_ALIGNED = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOMEM    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FIELD_W-1:0] request_bytes;
    logic [ALIGN_W-1:0] align_bytes;
    logic [31:0]        release_address;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        address;
    logic [FIELD_W-1:0] used_bytes;
    logic [FIELD_W-1:0] free_bytes;
    logic [FIELD_W-1:0] total_bytes;
  } out_t;

endpackage

// File: rtl/ffa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/first_fit_block_allocator.sv
// First-fit block allocator: block table walker and sequencer.
//
// An operation takes a transfer when start is high and busy is low. The block table sits in
// one RAM with one write and one registered read port, and a sequencer walks it one entry per
// cycle with a single address adder and compare. An allocate or free primes the first read,
// scans the entries ahead of the chosen block, then updates the table, shifting its tail one
// entry at a time when a split or merge needs it, and then gives the result. Free of address
// zero, zero-size plain allocates and the unused opcode go straight to the result. The result
// appears for exactly one cycle with done high and cannot be held off. After reset the block
// is busy while it writes the first table entry; heap_base may be written whenever the block
// is idle.
module first_fit_block_allocator #(
  parameter int HEAP_BYTES   = ffa_pkg::DEF_HEAP_BYTES,
  parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
  parameter int MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [31:0]  cfg_data,
  input  logic         start,
  input  ffa_pkg::in_t request,
  output logic         busy,
  output logic         done,
  output ffa_pkg::out_t result
);
  import ffa_pkg::*;
  `include "assert_macros.svh"

  localparam int SIZE_W = $clog2(HEAP_BYTES);
  localparam int ENT_W  = SIZE_W + 1;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = WANT_W + 1;

  localparam logic [31:0]        HDR32   = 32'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0]  HDR_S   = SIZE_W'(HEADER_BYTES);
  localparam logic [FIELD_W-1:0] HDR_F   = FIELD_W'(HEADER_BYTES);
  localparam logic [FIELD_W-1:0] HEAP_F  = FIELD_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0]  INIT_SZ = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CNT_W-1:0]   MAX_C   = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PRIME, S_SCAN, S_SHUP, S_WREM, S_WSEL, S_FRNX, S_SHDN, S_DONE
  } state_t;

  state_t              state;
  logic [31:0]         heap_base;
  logic [CNT_W-1:0]    count;
  logic [FIELD_W-1:0]  used;
  logic [1:0]          op;
  logic [1:0]          status;
  logic [WANT_W-1:0]   want;
  logic [ALIGN_W-1:0]  align;
  logic [31:0]         rel;
  logic [CNT_W-1:0]    idx;
  logic [31:0]         daddr;
  logic [SIZE_W-1:0]   sel_size;
  logic                split;
  logic [IDX_W-1:0]    k;
  logic [IDX_W-1:0]    k_lag;
  logic                reading;
  logic                vq;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [ENT_W-1:0]    wdata;
  logic [IDX_W-1:0]    raddr;
  logic [ENT_W-1:0]    rdata;

  logic                ent_free;
  logic [SIZE_W-1:0]   ent_size;
  logic                fits;
  logic                can_split;
  logic                merge;
  logic [ALIGN_W-1:0]  align_eff;
  logic [WANT_W-1:0]   want_raw;
  logic [WANT_W-1:0]   want_rnd;
  logic [31:0]         a32;
  logic [31:0]         ret_addr;
  logic [CNT_W-1:0]    idx_p1;
  logic [CNT_W-1:0]    idx_p2;

  ffa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ent_free  = rdata[SIZE_W];
  assign ent_size  = rdata[SIZE_W-1:0];
  assign fits      = ent_free && (WANT_W'(ent_size) >= want);
  assign can_split = (count < MAX_C) &&
                     (CMP_W'(ent_size) >= CMP_W'(want) + CMP_W'(HEADER_BYTES) +
                                          CMP_W'(SPLIT_SLACK));
  assign idx_p1    = idx + CNT_W'(1);
  assign idx_p2    = idx + CNT_W'(2);
  assign merge     = (idx_p1 < count) && ent_free;

  assign align_eff = (request.align_bytes == '0) ? ALIGN_W'(1) : request.align_bytes;
  assign want_raw  = (request.opcode == OP_ALIGNED) ?
                     WANT_W'(request.request_bytes) + WANT_W'(align_eff) :
                     WANT_W'(request.request_bytes);
  assign want_rnd  = (want_raw + WANT_W'(3)) & ~WANT_W'(3);

  assign a32       = 32'(align);
  assign ret_addr  = (status != ST_OK || (op != OP_ALLOC && op != OP_ALIGNED)) ? 32'd0 :
                     (op == OP_ALIGNED) ? ((daddr + a32 - 32'd1) & ~(a32 - 32'd1)) : daddr;

  assign busy = rst || (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = idx[IDX_W-1:0];
    wdata = {1'b0, sel_size};
    raddr = k;
    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, INIT_SZ};
      end
      S_PRIME: raddr = '0;
      S_SCAN:  raddr = idx_p1[IDX_W-1:0];
      S_SHUP: begin
        we    = vq;
        waddr = k_lag + IDX_W'(1);
        wdata = rdata;
      end
      S_WREM: begin
        we    = 1'b1;
        waddr = idx_p1[IDX_W-1:0];
        wdata = {1'b1, sel_size - SIZE_W'(want) - HDR_S};
      end
      S_WSEL: begin
        we    = 1'b1;
        wdata = {1'b0, split ? SIZE_W'(want) : sel_size};
      end
      S_FRNX: begin
        we    = 1'b1;
        wdata = {1'b1, merge ? sel_size + HDR_S + ent_size : sel_size};
      end
      S_SHDN: begin
        we    = vq;
        waddr = k_lag - IDX_W'(1);
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      heap_base <= HEAP_BASE_RESET;
      count     <= CNT_W'(1);
      used      <= '0;
      done      <= 1'b0;
      reading   <= 1'b0;
      vq        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        heap_base <= cfg_data;
      end
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            op     <= request.opcode;
            align  <= align_eff;
            rel    <= request.release_address;
            want   <= want_rnd;
            idx    <= '0;
            daddr  <= heap_base + HDR32;
            status <= ST_OK;
            priority case (1'b1)
              (request.opcode == OP_ALLOC || request.opcode == OP_ALIGNED): begin
                if (want_raw == '0) begin
                  status <= ST_NOMEM;
                  state  <= S_DONE;
                end else begin
                  state <= S_PRIME;
                end
              end
              (request.opcode == OP_FREE && request.release_address != '0):
                state <= S_PRIME;
              default: state <= S_DONE;
            endcase
          end
        end
        S_PRIME: state <= S_SCAN;
        S_SCAN: begin
          if (idx >= count) begin
            status <= (op == OP_FREE) ? ST_NOTFOUND : ST_NOMEM;
            state  <= S_DONE;
          end else if (op != OP_FREE && fits) begin
            sel_size <= ent_size;
            split    <= can_split;
            used     <= used + FIELD_W'(can_split ? want : WANT_W'(ent_size)) + HDR_F;
            k        <= IDX_W'(count - CNT_W'(1));
            reading  <= 1'b1;
            vq       <= 1'b0;
            if (!can_split) begin
              state <= S_WSEL;
            end else if (idx_p2 <= count) begin
              state <= S_SHUP;
            end else begin
              state <= S_WREM;
            end
          end else if (op == OP_FREE && daddr == rel) begin
            if (ent_free) begin
              status <= ST_NOTFOUND;
              state  <= S_DONE;
            end else begin
              sel_size <= ent_size;
              used     <= used - FIELD_W'(ent_size) - HDR_F;
              state    <= S_FRNX;
            end
          end else begin
            idx   <= idx_p1;
            daddr <= daddr + 32'(ent_size) + HDR32;
          end
        end
        S_SHUP: begin
          k_lag <= k;
          vq    <= reading;
          if (reading) begin
            if (CNT_W'(k) == idx_p1) begin
              reading <= 1'b0;
            end else begin
              k <= k - IDX_W'(1);
            end
          end else if (!vq) begin
            state <= S_WREM;
          end
        end
        S_WREM: begin
          count <= count + CNT_W'(1);
          state <= S_WSEL;
        end
        S_WSEL: state <= S_DONE;
        S_FRNX: begin
          if (merge) begin
            count <= count - CNT_W'(1);
          end
          if (merge && idx_p2 < count) begin
            k       <= idx_p2[IDX_W-1:0];
            reading <= 1'b1;
            vq      <= 1'b0;
            state   <= S_SHDN;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHDN: begin
          k_lag <= k;
          vq    <= reading;
          if (reading) begin
            if (CNT_W'(k) == count) begin
              reading <= 1'b0;
            end else begin
              k <= k + IDX_W'(1);
            end
          end else if (!vq) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          result.status      <= status;
          result.address     <= ret_addr;
          result.used_bytes  <= used;
          result.free_bytes  <= HEAP_F - used;
          result.total_bytes <= HEAP_F;
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFA_ASSERT(a_count_range, (count >= CNT_W'(1)) && (count <= MAX_C), "block count out of range")
  `FFA_ASSERT(a_stats_sum, done |-> (result.used_bytes + result.free_bytes == HEAP_F), "stats mismatch")
  `FFA_ASSERT(a_start_busy, (start && !busy) |=> busy, "transfer did not make block busy")
  `FFA_ASSERT_ALWAYS(a_rst_quiet, rst |=> !done, "result strobe after reset")

endmodule
